/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/mctp_pkg.sv */
// Constants and request codes for the multi-channel tick PWM.
package mctp_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int REQ_W  = 2;
  localparam int CHAN_W = 3;
  localparam int DUTY_W = 8;
  localparam int PINS_W = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 2'd3;

  // setpoint that keeps a channel on for the whole period
  localparam logic [DUTY_W-1:0] FULL_ON = 8'hff;

endpackage

/* rtl/multi_channel_tick_pwm.sv */
// Multi-channel 8-bit PWM generator advanced by tick requests.
//
// Input channel (in_valid / in_stall): req_type, channel, duty. A tick advances
// the shared 8-bit period counter and updates every enabled channel; set duty
// stores a setpoint, enable clears both duties of a channel, disable freezes
// its output level. Requests to a channel at or above CHANNELS are ignored.
// Output channel (out_valid / out_stall): one result per request, giving the
// pin levels of channels 0..7, the counter after the request and whether
// the tick handled counter value zero.
// A request passes through the input register, then the channel update logic
// feeding the result register. Throughput is one request per cycle while no
// result is held by out_stall; the result register and the input register
// form a two-deep pipe, so a new request is taken while a result waits.
// Reset (rst, synchronous) clears the counter, all duties, enables and levels
// and empties the pipe. While out_stall is high the result holds; the input
// register keeps its request and in_stall rises once it is full.
`include "assert_macros.svh"

module multi_channel_tick_pwm #(
  parameter int CHANNELS = mctp_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mctp_pkg::REQ_W-1:0]      req_type,
  input  logic [mctp_pkg::CHAN_W-1:0]     channel,
  input  logic [mctp_pkg::DUTY_W-1:0]     duty,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mctp_pkg::PINS_W-1:0]     pin_levels,
  output logic [mctp_pkg::DUTY_W-1:0]     cycle_position,
  output logic                            period_start
);
  import mctp_pkg::*;

  localparam int LevelW = (CHANNELS > PINS_W) ? CHANNELS : PINS_W;

  // input register
  logic                s1_valid;
  logic [REQ_W-1:0]    s1_req;
  logic [CHAN_W-1:0]   s1_chan;
  logic [DUTY_W-1:0]   s1_duty;

  // PWM state
  logic [DUTY_W-1:0]                count;
  logic [CHANNELS-1:0][DUTY_W-1:0]  setpoint;
  logic [CHANNELS-1:0][DUTY_W-1:0]  active;
  logic [CHANNELS-1:0]              on;
  logic [CHANNELS-1:0]              level;

  logic [DUTY_W-1:0]                count_next;
  logic [CHANNELS-1:0][DUTY_W-1:0]  setpoint_next;
  logic [CHANNELS-1:0][DUTY_W-1:0]  active_next;
  logic [CHANNELS-1:0]              on_next;
  logic [CHANNELS-1:0]              level_next;
  logic [LevelW-1:0]                level_pad;
  logic [CHANNELS-1:0]              hit;
  logic                             start_next;

  logic adv;
  logic in_xfer;

  // pipe control
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req  <= req_type;
      s1_chan <= channel;
      s1_duty <= duty;
    end
  end

  // channel select decode
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      hit[c] = (int'(s1_chan) == c);
    end
  end

  // per-channel update for the request in the input register
  always_comb begin
    count_next    = count;
    setpoint_next = setpoint;
    active_next   = active;
    on_next       = on;
    level_next    = level;
    start_next    = 1'b0;
    unique case (s1_req)
      REQ_TICK: begin
        start_next = (count == '0);
        count_next = count + DUTY_W'(1);
        for (int c = 0; c < CHANNELS; c++) begin
          if (on[c]) begin
            if (count == '0) begin
              active_next[c] = setpoint[c];
              level_next[c]  = (setpoint[c] != '0);
            end else if (count == active[c] && setpoint[c] != FULL_ON) begin
              level_next[c] = 1'b0;
            end
          end
        end
      end
      REQ_SET: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (hit[c]) setpoint_next[c] = s1_duty;
        end
      end
      REQ_ENABLE: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (hit[c]) begin
            on_next[c]       = 1'b1;
            setpoint_next[c] = '0;
            active_next[c]   = '0;
          end
        end
      end
      REQ_DISABLE: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (hit[c]) on_next[c] = 1'b0;
        end
      end
      default: begin
        start_next = 1'b0;
      end
    endcase
  end

  assign level_pad = LevelW'(level_next);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      setpoint <= '0;
      active   <= '0;
      on       <= '0;
      level    <= '0;
    end else if (adv) begin
      count    <= count_next;
      setpoint <= setpoint_next;
      active   <= active_next;
      on       <= on_next;
      level    <= level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pin_levels     <= level_pad[PINS_W-1:0];
      cycle_position <= count_next;
      period_start   <= start_next;
    end
  end

  // checks
  `ASSERT_CLK(a_adv_gives_result, clk, rst, adv |=> out_valid)
  `ASSERT_CLK(a_tick_counts, clk, rst, adv && s1_req == REQ_TICK |=> count == $past(count) + 1'b1)
  `ASSERT_CLK(a_other_holds_count, clk, rst, (adv && s1_req != REQ_TICK) |=> $stable(count))
  `ASSERT_CLK(a_start_at_one, clk, rst, out_valid && period_start |-> cycle_position == DUTY_W'(1))
  `ASSERT_CLK(a_disabled_frozen, clk, rst, adv |=> (level & ~$past(on)) == $past(level & ~on))
  `ASSERT_CLK_ALWAYS(a_reset_empties, clk, rst |=> (!out_valid && !s1_valid))

endmodule
